### design/smx_pkg.sv
`default_nettype none

package smx_pkg;

  localparam int unsigned MAX_ROW_DEF  = 64;
  localparam int unsigned SERIES_TERMS = 20;
  localparam int unsigned DIV_BITS     = 31;
  localparam int unsigned OUT_BITS     = 7;
  localparam logic [6:0]  ROW_LEN_RST  = 7'd64;
  localparam logic [15:0] EXP_CUTOFF   = 16'd3072;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [23:0] SUM_LIMIT    = 24'hFF_FFFF;

  typedef struct packed {
    logic signed [15:0] score;
    logic        [15:0] row_scale;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] prob_code;
    logic              last_of_row;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SER_INIT,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACC,
    OP_SER_DONE,
    OP_K,
    OP_RMUL,
    OP_RRND,
    OP_EFIN,
    OP_OMUL,
    OP_ODIV_INIT,
    OP_ODIV_STEP,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       x_full;  // series argument is one whole unit (256)
    logic [4:0] step;    // term number or quotient bit position
    logic       last;
  } smx_cmd_t;

  typedef struct packed {
    logic       k_big;
    logic [3:0] k_hi;
    logic       out_free;
  } smx_sts_t;

endpackage

`default_nettype wire

### design/smx_ram.sv
`default_nettype none

module smx_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/smx_dp.sv
`default_nettype none

module smx_dp
  import smx_pkg::*;
#(
  parameter int unsigned MAX_ROW = MAX_ROW_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire smx_cmd_t                   cmd_i,
  output smx_sts_t                        sts_o,
  input  wire logic [$clog2(MAX_ROW)-1:0] waddr_i,
  input  wire logic [$clog2(MAX_ROW)-1:0] idx_i,
  input  wire in_item_t                   in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output out_item_t                       out_data_o
);

  logic signed [15:0] max_q;
  logic [23:0]        sum_q;
  logic [15:0]        scale_q;
  logic [15:0]        k_q;
  logic               big_q;
  logic [8:0]         x_q;
  logic [30:0]        term_q;
  logic signed [32:0] acc_q;
  logic [39:0]        prod_q;
  logic [30:0]        dq_q;
  logic [4:0]         rem_q;
  logic [30:0]        e1_q;
  logic [30:0]        r_q;
  logic [61:0]        rprod_q;
  logic [32:0]        oprod_q;
  logic [30:0]        orem_q;
  logic [6:0]         oq_q;
  logic               osat_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [15:0] store_rdata;
  logic [16:0] code_rdata;
  logic [16:0] e_code;
  logic [16:0] diff;
  logic [5:0]  dtrial;
  logic        dge;
  logic [30:0] dshift;
  logic [24:0] onum;
  logic [24:0] sum_ext;
  logic [30:0] acc_pos;
  logic [30:0] r_plus;
  logic [61:0] rnd;

  smx_ram #(.WIDTH(16), .DEPTH(MAX_ROW)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_LOAD),
    .waddr_i (waddr_i),
    .wdata_i (in_data_i.score),
    .raddr_i (idx_i),
    .rdata_o (store_rdata)
  );

  smx_ram #(.WIDTH(17), .DEPTH(MAX_ROW)) u_code (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_EFIN),
    .waddr_i (idx_i),
    .wdata_i (e_code),
    .raddr_i (idx_i),
    .rdata_o (code_rdata)
  );

  always_comb begin
    diff    = {max_q[15], max_q} - {store_rdata[15], store_rdata};
    dtrial  = {rem_q, dq_q[30]};
    dge     = dtrial >= {1'b0, cmd_i.step};
    dshift  = {7'd0, sum_q} << cmd_i.step[2:0];
    onum    = oprod_q[32:8];
    acc_pos = acc_q[32] ? 31'd0 : acc_q[30:0];
    r_plus  = r_q + 31'd8192;
    e_code  = big_q ? 17'd0 : r_plus[30:14];
    sum_ext = {1'b0, sum_q} + {8'd0, e_code};
    rnd     = rprod_q + 62'h2000_0000;
  end

  // The row maximum and the exponential sum are row state and restart from reset and after the row's last output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= -16'sd32768;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          if ($signed(in_data_i.score) > max_q) begin
            max_q <= in_data_i.score;
          end
        end
        OP_EFIN: begin
          sum_q <= sum_ext[24] ? SUM_LIMIT : sum_ext[23:0];
        end
        OP_OUT_LOAD: begin
          if (cmd_i.last) begin
            max_q <= -16'sd32768;
            sum_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        scale_q <= in_data_i.row_scale;
      end
      OP_K: begin
        k_q   <= diff[15:0];
        big_q <= diff[15:0] >= EXP_CUTOFF;
      end
      OP_SER_INIT: begin
        term_q <= Q30_ONE;
        acc_q  <= {2'b00, Q30_ONE};
        x_q    <= cmd_i.x_full ? 9'd256 : {1'b0, k_q[7:0]};
      end
      OP_MUL: begin
        prod_q <= term_q * x_q;
      end
      OP_DIV_INIT: begin
        dq_q  <= prod_q[38:8];
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= dge ? 5'(dtrial - {1'b0, cmd_i.step}) : dtrial[4:0];
        dq_q  <= {dq_q[29:0], dge};
      end
      OP_ACC: begin
        term_q <= dq_q;
        if (cmd_i.step[0]) begin
          acc_q <= acc_q - {2'b00, dq_q};
        end else begin
          acc_q <= acc_q + {2'b00, dq_q};
        end
      end
      OP_SER_DONE: begin
        if (cmd_i.x_full) begin
          e1_q <= acc_pos;
        end else begin
          r_q <= acc_pos;
        end
      end
      OP_RMUL: begin
        rprod_q <= r_q * e1_q;
      end
      OP_RRND: begin
        r_q <= rnd[60:30];
      end
      OP_OMUL: begin
        oprod_q <= code_rdata * scale_q;
      end
      OP_ODIV_INIT: begin
        orem_q <= {6'd0, onum};
        oq_q   <= '0;
        osat_q <= {6'd0, onum} >= {sum_q, 7'd0};
      end
      OP_ODIV_STEP: begin
        if (orem_q >= dshift) begin
          orem_q                  <= orem_q - dshift;
          oq_q[cmd_i.step[2:0]]   <= 1'b1;
        end
      end
      OP_OUT_LOAD: begin
        out_q.prob_code   <= osat_q ? 8'sd127 : $signed({1'b0, oq_q});
        out_q.last_of_row <= cmd_i.last;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.k_big    = big_q;
  assign sts_o.k_hi     = k_q[11:8];
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

### design/smx_ctrl.sv
`default_nettype none

module smx_ctrl
  import smx_pkg::*;
#(
  parameter int unsigned MAX_ROW = MAX_ROW_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       cfg_write_i,
  input  wire logic [6:0]                 cfg_data_i,
  input  wire smx_sts_t                   sts_i,
  output smx_cmd_t                        cmd_o,
  output logic [$clog2(MAX_ROW)-1:0]      waddr_o,
  output logic [$clog2(MAX_ROW)-1:0]      idx_o
);

  localparam int unsigned AW = $clog2(MAX_ROW);
  localparam int unsigned CW = $clog2(MAX_ROW + 1);

  typedef enum logic [4:0] {
    ST_LOAD, ST_SER_INIT, ST_MUL, ST_DIV_INIT, ST_DIV, ST_ACC, ST_SER_DONE,
    ST_RD, ST_KCALC, ST_KCHK, ST_RMUL, ST_RRND, ST_EFIN,
    ST_ORD, ST_OMUL, ST_ODIV_INIT, ST_ODIV, ST_OUT
  } state_e;

  state_e      state_q;
  logic [6:0]  row_len_q;
  logic [CW-1:0] fill_q;
  logic [AW-1:0] idx_q;
  logic [4:0]  nterm_q;
  logic [4:0]  cnt_q;
  logic [3:0]  acnt_q;
  logic        e1_mode_q;

  logic [CW-1:0] len_eff;
  logic [CW-1:0] fill_next;
  logic          idx_last;

  always_comb begin
    if (row_len_q == 7'd0) begin
      len_eff = CW'(1);
    end else if (32'(row_len_q) > MAX_ROW) begin
      len_eff = CW'(MAX_ROW);
    end else begin
      len_eff = CW'(row_len_q);
    end
    fill_next = fill_q + CW'(1);
    idx_last  = (CW'(idx_q) + CW'(1)) == fill_q;
  end

  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.x_full = e1_mode_q;
    cmd_o.step   = nterm_q;
    cmd_o.last   = idx_last;
    case (state_q)
      ST_LOAD:      cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_SER_INIT:  cmd_o.op = OP_SER_INIT;
      ST_MUL:       cmd_o.op = OP_MUL;
      ST_DIV_INIT:  cmd_o.op = OP_DIV_INIT;
      ST_DIV:       cmd_o.op = OP_DIV_STEP;
      ST_ACC:       cmd_o.op = OP_ACC;
      ST_SER_DONE:  cmd_o.op = OP_SER_DONE;
      ST_KCALC:     cmd_o.op = OP_K;
      ST_RMUL:      cmd_o.op = OP_RMUL;
      ST_RRND:      cmd_o.op = OP_RRND;
      ST_EFIN:      cmd_o.op = OP_EFIN;
      ST_OMUL:      cmd_o.op = OP_OMUL;
      ST_ODIV_INIT: cmd_o.op = OP_ODIV_INIT;
      ST_ODIV: begin
        cmd_o.op   = OP_ODIV_STEP;
        cmd_o.step = cnt_q;
      end
      ST_OUT:       cmd_o.op = sts_i.out_free ? OP_OUT_LOAD : OP_NONE;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o = state_q != ST_LOAD;
  assign waddr_o    = fill_q[AW-1:0];
  assign idx_o      = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      row_len_q <= ROW_LEN_RST;
      fill_q    <= '0;
      idx_q     <= '0;
      nterm_q   <= '0;
      cnt_q     <= '0;
      acnt_q    <= '0;
      e1_mode_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        row_len_q <= cfg_data_i;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            fill_q <= fill_next;
            if (fill_next >= len_eff) begin
              e1_mode_q <= 1'b1;
              idx_q     <= '0;
              state_q   <= ST_SER_INIT;
            end
          end
        end
        ST_SER_INIT: begin
          nterm_q <= 5'd1;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(DIV_BITS - 1)) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (nterm_q == 5'(SERIES_TERMS)) begin
            state_q <= ST_SER_DONE;
          end else begin
            nterm_q <= nterm_q + 5'd1;
            state_q <= ST_MUL;
          end
        end
        ST_SER_DONE: begin
          acnt_q <= '0;
          if (e1_mode_q) begin
            e1_mode_q <= 1'b0;
            state_q   <= ST_RD;
          end else if (sts_i.k_hi == 4'd0) begin
            state_q <= ST_EFIN;
          end else begin
            state_q <= ST_RMUL;
          end
        end
        ST_RD: begin
          state_q <= ST_KCALC;
        end
        ST_KCALC: begin
          state_q <= ST_KCHK;
        end
        ST_KCHK: begin
          state_q <= sts_i.k_big ? ST_EFIN : ST_SER_INIT;
        end
        ST_RMUL: begin
          state_q <= ST_RRND;
        end
        ST_RRND: begin
          acnt_q  <= acnt_q + 4'd1;
          state_q <= ((acnt_q + 4'd1) == sts_i.k_hi) ? ST_EFIN : ST_RMUL;
        end
        ST_EFIN: begin
          if (idx_last) begin
            idx_q   <= '0;
            state_q <= ST_ORD;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= ST_RD;
          end
        end
        ST_ORD: begin
          state_q <= ST_OMUL;
        end
        ST_OMUL: begin
          state_q <= ST_ODIV_INIT;
        end
        ST_ODIV_INIT: begin
          cnt_q   <= 5'(OUT_BITS - 1);
          state_q <= ST_ODIV;
        end
        ST_ODIV: begin
          if (cnt_q == 5'd0) begin
            state_q <= ST_OUT;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_OUT: begin
          if (sts_i.out_free) begin
            if (idx_last) begin
              fill_q  <= '0;
              idx_q   <= '0;
              state_q <= ST_LOAD;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= ST_ORD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/softmax_row_int8_top.sv
// Row softmax with signed 8-bit output.
// Scores (signed Q8.8) enter on the input channel, one transfer per cycle,
// while the block collects a row; row_length scores (at least one, at most
// MAX_ROW) make a row. The row_scale that comes with the last score of the
// row sets the output scale. After the last score the input stalls while the
// block works out the exponential of every score against the row maximum and
// sums them. The constant exp(-1) is worked out first for every row. Each
// exponential runs a 20-term series through a bit-serial divider and then up
// to eleven fixed-point multiplies; a score 12.0 or more below the maximum
// skips the series. Results then leave in arrival order, each scaled and
// divided before the next one starts, with last_of_row set on the final one.
// A stalled output holds its result and pauses the block. The configuration
// channel writes row_length and is always ready; write it only while idle.
// Reset empties the current row and sets row_length to 64.
`default_nettype none

module softmax_row_int8_top
  import smx_pkg::*;
#(
  parameter int unsigned MAX_ROW = MAX_ROW_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [6:0] cfg_data_i
);

  smx_cmd_t                   cmd;
  smx_sts_t                   sts;
  logic [$clog2(MAX_ROW)-1:0] waddr;
  logic [$clog2(MAX_ROW)-1:0] idx;

  assign cfg_ready_o = 1'b1;

  smx_ctrl #(.MAX_ROW(MAX_ROW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .waddr_o     (waddr),
    .idx_o       (idx)
  );

  smx_dp #(.MAX_ROW(MAX_ROW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .waddr_i     (waddr),
    .idx_i       (idx),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
